/* design/mplb_pkg.sv */
// Shared types and constants for the multi-pool minimal-standard generator bank.
// Holds opcode and status codes and the generator's modulus and multiplier.
// No dependencies.
package mplb_pkg;

    localparam int SEED_W   = 31;
    localparam int OP_W     = 2;
    localparam int POOL_W   = 3;
    localparam int STATUS_W = 2;
    localparam int MUL_W    = 15;
    localparam int PROD_W   = SEED_W + MUL_W;

    localparam logic [SEED_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
    localparam logic [MUL_W-1:0]  LCG_MUL = 15'd16807;

    // Only this many pools can ever be addressed by the pool field.
    localparam int ADDR_POOLS = 1 << POOL_W;

    typedef enum logic [OP_W-1:0] {
        OP_SEED_ALL  = 2'd0,
        OP_SET_SEED  = 2'd1,
        OP_READ_SEED = 2'd2,
        OP_NEXT      = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 2'd0,
        ST_ZERO_SEED      = 2'd1,
        ST_ALREADY_SEEDED = 2'd2
    } status_t;

endpackage

/* design/mplb_lcg_step.sv */
// One step of the minimal-standard generator: multiply by 16807 modulo 2^31-1.
// The product is folded at bit 31 and corrected once; a zero result becomes 2^31-1.
// Depends on mplb_pkg.
module mplb_lcg_step
(
    input  logic [mplb_pkg::SEED_W-1:0] cur_state,
    output logic [mplb_pkg::SEED_W-1:0] next_state
);
    import mplb_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [SEED_W:0]   fold_sum;
    logic [SEED_W:0]   reduced;

    always_comb
    begin
        prod     = {{MUL_W{1'b0}}, cur_state} * {{SEED_W{1'b0}}, LCG_MUL};
        fold_sum = {1'b0, prod[SEED_W-1:0]} + {{(SEED_W + 1 - MUL_W){1'b0}}, prod[PROD_W-1:SEED_W]};
        if (fold_sum >= {1'b0, LCG_MOD})
        begin
            reduced = fold_sum - {1'b0, LCG_MOD};
        end
        else
        begin
            reduced = fold_sum;
        end
        if (reduced[SEED_W-1:0] == '0)
        begin
            next_state = LCG_MOD;
        end
        else
        begin
            next_state = reduced[SEED_W-1:0];
        end
    end

endmodule

/* design/multi_pool_lcg_bank.sv */
// Bank of independent minimal-standard random generators with seed, read and step requests.
// Accepted requests are registered, then their results are registered as the response.
// Throughput: one request per cycle without stalls; step and state write share a cycle.
// Reset clears every pool state to zero, the seeded flag, and both pipeline valids.
// Depends on mplb_pkg and mplb_lcg_step.
module multi_pool_lcg_bank #(
    parameter int NUM_POOLS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [mplb_pkg::OP_W-1:0]     opcode,
    input  logic [mplb_pkg::POOL_W-1:0]   pool,
    input  logic [mplb_pkg::SEED_W-1:0]   seed,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [mplb_pkg::SEED_W-1:0]   value,
    output logic [mplb_pkg::STATUS_W-1:0] status
);
    import mplb_pkg::*;

    // Pools beyond the reach of the pool field are never observable.
    localparam int STORE_POOLS = (NUM_POOLS < ADDR_POOLS) ? NUM_POOLS : ADDR_POOLS;
    localparam int IDX_W       = (STORE_POOLS > 1) ? $clog2(STORE_POOLS) : 1;

    logic                req_valid_reg;
    logic [OP_W-1:0]     opcode_reg;
    logic [POOL_W-1:0]   pool_reg;
    logic [SEED_W-1:0]   seed_reg;

    logic                rsp_valid_reg;
    logic [SEED_W-1:0]   value_reg;
    status_t             status_reg;

    logic [SEED_W-1:0]   pool_state_reg [STORE_POOLS];
    logic [SEED_W-1:0]   pool_state_next [STORE_POOLS];
    logic                seeded_flag_reg;
    logic                seeded_flag_next;
    logic [SEED_W-1:0]   value_next;
    status_t             status_next;

    logic                advance;
    logic                pool_ok;
    logic [IDX_W-1:0]    idx;
    logic [SEED_W-1:0]   cur_state;
    logic [SEED_W-1:0]   step_state;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    assign pool_ok = (int'(pool_reg) < STORE_POOLS);
    assign idx     = pool_ok ? pool_reg[IDX_W-1:0] : '0;
    assign cur_state = pool_state_reg[idx];

    mplb_lcg_step u_step
    (
        .cur_state  (cur_state),
        .next_state (step_state)
    );

    always_comb
    begin
        pool_state_next  = pool_state_reg;
        seeded_flag_next = seeded_flag_reg;
        value_next       = '0;
        status_next      = ST_OK;
        unique case (opcode_t'(opcode_reg))
            OP_SEED_ALL:
            begin
                if (seed_reg == '0)
                begin
                    status_next = ST_ZERO_SEED;
                end
                else if (seeded_flag_reg)
                begin
                    status_next = ST_ALREADY_SEEDED;
                end
                else
                begin
                    for (int i = 0; i < STORE_POOLS; i++)
                    begin
                        pool_state_next[i] = seed_reg;
                    end
                    seeded_flag_next = 1'b1;
                end
            end
            OP_SET_SEED:
            begin
                if (seed_reg == '0)
                begin
                    status_next = ST_ZERO_SEED;
                end
                else if (pool_ok)
                begin
                    pool_state_next[idx] = seed_reg;
                end
            end
            OP_READ_SEED:
            begin
                if (pool_ok)
                begin
                    value_next = cur_state;
                end
            end
            OP_NEXT:
            begin
                if (pool_ok)
                begin
                    pool_state_next[idx] = step_state;
                    value_next           = step_state;
                end
            end
            default:
            begin
                value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            seeded_flag_reg <= 1'b0;
            for (int i = 0; i < STORE_POOLS; i++)
            begin
                pool_state_reg[i] <= '0;
            end
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
            if (req_valid_reg && advance)
            begin
                pool_state_reg  <= pool_state_next;
                seeded_flag_reg <= seeded_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            opcode_reg <= opcode;
            pool_reg   <= pool;
            seed_reg   <= seed;
        end
        if (req_valid_reg && advance)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    a_issue_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && advance) |=> rsp_valid_reg)
        else $error("issued request did not produce a result");

    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_flag_reg |=> seeded_flag_reg)
        else $error("seeded flag cleared after being set");

    a_already_means_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_ALREADY_SEEDED) |-> seeded_flag_reg)
        else $error("already-seeded status without seeded flag");

    a_seed_status_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_ZERO_SEED || status_reg == ST_ALREADY_SEEDED))
        |-> (value_reg == '0))
        else $error("rejected seeding returned a non-zero value");

endmodule

/* tb/multi_pool_lcg_bank_tb.sv */
// Self-checking testbench for multi_pool_lcg_bank: seed, read and step requests over all pools.
// A scoreboard class predicts every reply from its own copy of the pool states and seeded flag.
// Depends on mplb_pkg and the multi_pool_lcg_bank RTL.
module multi_pool_lcg_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mplb_pkg::*;

    localparam int NUM_POOLS = 8;
    localparam int HOLD_CYCLES = 300;

    class pool_bank_tracker;
        typedef struct {
            logic [SEED_W-1:0] value;
            status_t           status;
        } reply_t;

        logic [SEED_W-1:0] pool_state [ADDR_POOLS];
        bit                seeded;
        reply_t            pending_replies [$];
        int unsigned       mismatches;
        int unsigned       replies_checked;

        function new();
            foreach (pool_state[i])
            begin
                pool_state[i] = '0;
            end
            seeded = 1'b0;
            mismatches = 0;
            replies_checked = 0;
        endfunction

        function logic [SEED_W-1:0] minstd_next(logic [SEED_W-1:0] s);
            logic [63:0] product;
            logic [63:0] folded;
            product = {33'b0, s} * {49'b0, LCG_MUL};
            folded = (product & {33'b0, LCG_MOD}) + (product >> SEED_W);
            if (folded >= {33'b0, LCG_MOD})
            begin
                folded = folded - {33'b0, LCG_MOD};
            end
            if (folded == 64'd0)
            begin
                folded = {33'b0, LCG_MOD};
            end
            return folded[SEED_W-1:0];
        endfunction

        function void note_request(opcode_t op, logic [POOL_W-1:0] idx, logic [SEED_W-1:0] s);
            reply_t r;
            r.value = '0;
            r.status = ST_OK;
            case (op)
                OP_SEED_ALL:
                begin
                    if (s == '0)
                    begin
                        r.status = ST_ZERO_SEED;
                    end
                    else if (seeded)
                    begin
                        r.status = ST_ALREADY_SEEDED;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_POOLS; i++)
                        begin
                            pool_state[i] = s;
                        end
                        seeded = 1'b1;
                    end
                end
                OP_SET_SEED:
                begin
                    if (s == '0)
                    begin
                        r.status = ST_ZERO_SEED;
                    end
                    else if (idx < NUM_POOLS)
                    begin
                        pool_state[idx] = s;
                    end
                end
                OP_READ_SEED:
                begin
                    if (idx < NUM_POOLS)
                    begin
                        r.value = pool_state[idx];
                    end
                end
                default:
                begin
                    if (idx < NUM_POOLS)
                    begin
                        pool_state[idx] = minstd_next(pool_state[idx]);
                        r.value = pool_state[idx];
                    end
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [SEED_W-1:0] v, logic [STATUS_W-1:0] st);
            reply_t r;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, got value %h status %0d", $time, v, st);
                mismatches++;
                return;
            end
            r = pending_replies.pop_front();
            replies_checked++;
            if (v !== r.value)
            begin
                $display("%0t: value expected %h, got %h", $time, r.value, v);
                mismatches++;
            end
            if (st !== r.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, r.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [OP_W-1:0]     opcode = '0;
    logic [POOL_W-1:0]   pool = '0;
    logic [SEED_W-1:0]   seed = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [SEED_W-1:0]   value;
    logic [STATUS_W-1:0] status;

    pool_bank_tracker bank_tracker = new();

    bit          sender_idles = 1'b0;
    bit          receiver_idles = 1'b0;
    bit          start_hold = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned op_count [4] = '{0, 0, 0, 0};

    multi_pool_lcg_bank #(
        .NUM_POOLS(NUM_POOLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .opcode(opcode),
        .pool(pool),
        .seed(seed),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .value(value),
        .status(status)
    );

    always #5 clk = ~clk;

    task automatic send_request(opcode_t op, logic [POOL_W-1:0] idx, logic [SEED_W-1:0] s);
        req_valid <= 1'b1;
        opcode <= op;
        pool <= idx;
        seed <= s;
        do
        begin
            @(posedge clk);
        end
        while (req_ready !== 1'b1);
        bank_tracker.note_request(op, idx, s);
        op_count[op]++;
        if (sender_idles && $urandom_range(99) < 25)
        begin
            req_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < 25);
        end
    endtask

    function automatic logic [SEED_W-1:0] pick_seed();
        case ($urandom_range(9))
            0: return '0;
            1: return LCG_MOD;
            2: return SEED_W'($urandom_range(1, 20));
            default: return SEED_W'($urandom);
        endcase
    endfunction

    task automatic send_random_requests(int unsigned count);
        opcode_t op;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                op = OP_SEED_ALL;
            else if (pick < 30)
                op = OP_SET_SEED;
            else if (pick < 55)
                op = OP_READ_SEED;
            else
                op = OP_NEXT;
            send_request(op, POOL_W'($urandom_range(ADDR_POOLS - 1)), pick_seed());
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                bank_tracker.check_reply(value, status);
            end
            if (start_hold && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= !(receiver_idles && $urandom_range(99) < 25);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("multi_pool_lcg_bank: mismatch");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        // Unseeded pools read as zero and step to the all-ones state, which then holds.
        send_request(OP_READ_SEED, 3'd0, 31'd5);
        send_request(OP_NEXT, 3'd1, '0);
        send_request(OP_NEXT, 3'd1, '0);
        send_request(OP_SET_SEED, 3'd2, 31'h2AAA_AAAA);
        send_request(OP_SEED_ALL, 3'd7, '0);
        send_request(OP_SET_SEED, 3'd3, '0);
        send_request(OP_READ_SEED, 3'd2, '0);
        send_request(OP_SEED_ALL, 3'd0, LCG_MOD);
        send_request(OP_SEED_ALL, 3'd5, 31'd1);
        send_request(OP_SEED_ALL, 3'd5, '0);
        send_request(OP_READ_SEED, 3'd7, '0);
        send_request(OP_NEXT, 3'd7, '0);
        send_request(OP_SET_SEED, 3'd0, 31'd1);
        send_request(OP_NEXT, 3'd0, '0);
        send_request(OP_NEXT, 3'd0, '0);
        send_request(OP_SET_SEED, 3'd4, LCG_MOD - 31'd1);
        send_request(OP_NEXT, 3'd4, LCG_MOD);
        send_request(OP_SET_SEED, 3'd5, 31'h5555_5555);
        send_request(OP_NEXT, 3'd5, 31'h5555_5555);
        send_request(OP_READ_SEED, 3'd2, LCG_MOD);
        send_request(OP_READ_SEED, 3'd3, '0);

        send_random_requests(700);

        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        send_random_requests(600);

        start_hold = 1'b1;
        send_random_requests(100);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        send_random_requests(600);
        req_valid <= 1'b0;

        while (bank_tracker.pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d requests: %0d seed-all, %0d set, %0d read, %0d step.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_SEED_ALL], op_count[OP_SET_SEED],
                 op_count[OP_READ_SEED], op_count[OP_NEXT]);
        $display("Checked %0d replies, including a %0d-cycle reply hold with a full pipeline.",
                 bank_tracker.replies_checked, HOLD_CYCLES);
        if (bank_tracker.mismatches == 0 && bank_tracker.pending_replies.size() == 0)
        begin
            $display("multi_pool_lcg_bank: match");
        end
        else
        begin
            $display("multi_pool_lcg_bank: mismatch");
        end
        $finish;
    end

endmodule
